/* hw/rtl/lcjt_pkg.sv */
// ----------------------------------------------------------------------------
// lcjt_pkg
// Shared widths, register codes, reset values, clamp windows and the
// quarter-wave sine entry function for the linear chirp joint target block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcjt_pkg;

    localparam int JOINT_COUNT_DEF = 12;
    localparam int SINE_DEPTH_DEF  = 256;
    localparam int PHASE_BITS_DEF  = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int MASK_W      = 12;
    localparam int AMP_W       = 16;
    localparam int MAG_W       = 16;
    localparam int JOINT_W     = 4;
    localparam int POS_W       = 16;
    localparam int PROD_W      = AMP_W + MAG_W;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INIT_STEP = 3'd0,
        REG_STEP_INC  = 3'd1,
        REG_DIR_MASK  = 3'd2,
        REG_AMP_ABD   = 3'd3,
        REG_AMP_FLEX  = 3'd4,
        REG_AMP_KNEE  = 3'd5
    } t_reg_index;

    localparam logic [STEP_W-1:0] RST_INIT_STEP = 32'd8714489;
    localparam logic [STEP_W-1:0] RST_STEP_INC  = 32'd249108;
    localparam logic [MASK_W-1:0] RST_DIR_MASK  = 12'd970;
    localparam logic [AMP_W-1:0]  RST_AMP_ABD   = 16'd13107;
    localparam logic [AMP_W-1:0]  RST_AMP_FLEX  = 16'd19661;
    localparam logic [AMP_W-1:0]  RST_AMP_KNEE  = 16'd26214;

    // Rounding offset for Q1.31 -> Q2.13
    localparam int                ROUND_SHIFT = 18;
    localparam logic [PROD_W-1:0] ROUND_HALF  = 32'd131072;

    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint          ONE_Q30  = 64'sd1073741824;
    localparam longint unsigned HALF_Q30 = 64'd536870912;
    localparam longint unsigned SINE_MAX = 64'd32767;

    typedef struct packed {
        logic [STEP_W-1:0] init_step;
        logic [STEP_W-1:0] step_inc;
        logic [MASK_W-1:0] dir_mask;
        logic [AMP_W-1:0]  amp_abd;
        logic [AMP_W-1:0]  amp_flex;
        logic [AMP_W-1:0]  amp_knee;
    } t_cfg;

    // Sine result of one tick, handed from the phase engine to the joint unit
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_tick;

    function automatic logic signed [POS_W-1:0] clamp_lo(input logic [JOINT_W-1:0] j);
        logic signed [POS_W-1:0] lo;
        unique case (j)
            4'd0, 4'd1, 4'd2, 4'd3: lo = -16'sd6024;
            4'd4, 4'd5:             lo = -16'sd9599;
            4'd6, 4'd7:             lo = -16'sd6740;
            4'd8, 4'd9:             lo = -16'sd7960;
            4'd10, 4'd11:           lo = -16'sd6144;
            default:                lo = 16'sd0;
        endcase
        return lo;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_hi(input logic [JOINT_W-1:0] j);
        logic signed [POS_W-1:0] hi;
        unique case (j)
            4'd0, 4'd1, 4'd2, 4'd3: hi = 16'sd6024;
            4'd4, 4'd5:             hi = 16'sd6739;
            4'd6, 4'd7:             hi = 16'sd9599;
            4'd8, 4'd9:             hi = 16'sd6144;
            4'd10, 4'd11:           hi = 16'sd7960;
            default:                hi = 16'sd0;
        endcase
        return hi;
    endfunction

    // Quarter-wave entry i of a table with 2^log2d steps, Q1.15, built from
    // a nine-term fixed-point Taylor series. Evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i,
                                                    input int unsigned log2d);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          s;
        x    = (64'(i) * PI_Q30) >> (log2d + 1);
        x2   = (x * x) >> 30;
        term = x;
        s    = signed'(x);
        term = ((term * x2) >> 30) / 6;
        s    = s - signed'(term);
        term = ((term * x2) >> 30) / 20;
        s    = s + signed'(term);
        term = ((term * x2) >> 30) / 42;
        s    = s - signed'(term);
        term = ((term * x2) >> 30) / 72;
        s    = s + signed'(term);
        term = ((term * x2) >> 30) / 110;
        s    = s - signed'(term);
        term = ((term * x2) >> 30) / 156;
        s    = s + signed'(term);
        term = ((term * x2) >> 30) / 210;
        s    = s - signed'(term);
        term = ((term * x2) >> 30) / 272;
        s    = s + signed'(term);
        if (s < 0) begin
            s = 0;
        end
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        v = (unsigned'(s) * SINE_MAX + HALF_Q30) >> 30;
        if (v > SINE_MAX) begin
            v = SINE_MAX;
        end
        return MAG_W'(v);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/linear_chirp_joint_targets.sv */
// ----------------------------------------------------------------------------
// linear_chirp_joint_targets
// Linear chirp generator that turns each control tick into one target
// position per joint. Input beats (i_valid/o_stall) carry hold_start; output
// beats (o_valid/i_stall) carry joint index, clamped Q2.13 target and a
// last-joint flag, JOINT_COUNT beats per tick in joint order. Registers are
// to be written through i_cfg_we/i_cfg_index/i_cfg_data only while the block
// is idle; the block does not enforce this. init_step takes effect at the
// next hold tick, the rest with the next tick. The phase engine accepts a
// beat in ST_IDLE, writes phase in ST_UPDATE and step in ST_STEP, then holds
// the finished tick in its slot and takes the next beat once the joint unit
// takes that tick, while results still drain. Each tick then passes the joint
// unit's tick, multiply and output registers on its single multiply lane.
// Reset clears all control state and restores register defaults; no clearing
// pass is needed. A stalled receiver freezes the joint pipeline with the
// current result held; ticks are still accepted until the tick slot is full.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_chirp_joint_targets #(
    parameter int JOINT_COUNT      = lcjt_pkg::JOINT_COUNT_DEF,
    parameter int SINE_TABLE_DEPTH = lcjt_pkg::SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = lcjt_pkg::PHASE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_hold_start,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic        [lcjt_pkg::JOINT_W-1:0]       o_joint_index,
    output logic signed [lcjt_pkg::POS_W-1:0]         o_target_position,
    output logic                                      o_last_joint,
    input  wire logic                                 i_cfg_we,
    input  wire logic   [lcjt_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic   [lcjt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lcjt_pkg::*;

    t_cfg  cfg;
    t_tick tick;
    logic  tick_take;

    lcjt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lcjt_phase_engine #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .PHASE_BITS      (PHASE_BITS)
    ) u_phase_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_hold_start(i_hold_start),
        .o_stall     (o_stall),
        .i_cfg       (cfg),
        .o_tick      (tick),
        .i_tick_take (tick_take)
    );

    lcjt_joint_unit #(
        .JOINT_COUNT(JOINT_COUNT)
    ) u_joint_unit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_tick           (tick),
        .o_tick_take      (tick_take),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_joint_index    (o_joint_index),
        .o_target_position(o_target_position),
        .o_last_joint     (o_last_joint)
    );

endmodule

`default_nettype wire

/* hw/rtl/lcjt_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lcjt_cfg_regs
// Configuration register file: chirp steps, direction mask and amplitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module lcjt_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lcjt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [lcjt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lcjt_pkg::t_cfg                      o_cfg
);
    import lcjt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_step <= RST_INIT_STEP;
            r_cfg.step_inc  <= RST_STEP_INC;
            r_cfg.dir_mask  <= RST_DIR_MASK;
            r_cfg.amp_abd   <= RST_AMP_ABD;
            r_cfg.amp_flex  <= RST_AMP_FLEX;
            r_cfg.amp_knee  <= RST_AMP_KNEE;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_INIT_STEP: r_cfg.init_step <= i_cfg_data[STEP_W-1:0];
                REG_STEP_INC:  r_cfg.step_inc  <= i_cfg_data[STEP_W-1:0];
                REG_DIR_MASK:  r_cfg.dir_mask  <= i_cfg_data[MASK_W-1:0];
                REG_AMP_ABD:   r_cfg.amp_abd   <= i_cfg_data[AMP_W-1:0];
                REG_AMP_FLEX:  r_cfg.amp_flex  <= i_cfg_data[AMP_W-1:0];
                REG_AMP_KNEE:  r_cfg.amp_knee  <= i_cfg_data[AMP_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/lcjt_sine_rom.sv */
// ----------------------------------------------------------------------------
// lcjt_sine_rom
// Quarter-wave sine ROM, SINE_TABLE_DEPTH+1 entries in Q1.15, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lcjt_sine_rom #(
    parameter int SINE_TABLE_DEPTH = lcjt_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic [$clog2(SINE_TABLE_DEPTH):0]   i_addr,
    output logic      [lcjt_pkg::MAG_W-1:0]          o_data
);
    import lcjt_pkg::*;

    localparam int SINE_LOG2 = $clog2(SINE_TABLE_DEPTH);

    logic [MAG_W-1:0] w_rom [0:SINE_TABLE_DEPTH];
    logic [MAG_W-1:0] r_data;

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = sine_entry(gi, SINE_LOG2);
        assign w_rom[gi] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* hw/rtl/lcjt_phase_engine.sv */
// ----------------------------------------------------------------------------
// lcjt_phase_engine
// Holds phase and phase step in a two-word state memory, updates them once per
// tick and looks up the sine magnitude and sign of the tick's phase.
// ----------------------------------------------------------------------------
`default_nettype none

module lcjt_phase_engine #(
    parameter int SINE_TABLE_DEPTH = lcjt_pkg::SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = lcjt_pkg::PHASE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_hold_start,
    output logic                o_stall,
    input  lcjt_pkg::t_cfg      i_cfg,
    output lcjt_pkg::t_tick     o_tick,
    input  wire logic           i_tick_take
);
    import lcjt_pkg::*;

    localparam int SINE_LOG2 = $clog2(SINE_TABLE_DEPTH);
    localparam int ADDR_W    = SINE_LOG2 + 1;
    localparam int POS_BITS  = SINE_LOG2 + 2;

    localparam logic ADDR_PHASE = 1'b0;
    localparam logic ADDR_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_STEP   = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [PHASE_BITS-1:0] r_state_mem [0:1];
    logic [PHASE_BITS-1:0] r_rd_phase;
    logic [PHASE_BITS-1:0] r_rd_step;
    logic                  r_mem_valid;
    logic                  r_hold;
    logic [PHASE_BITS-1:0] r_new_step;
    logic                  r_q1;
    logic                  r_slot_valid;
    logic                  r_slot_neg;
    logic [MAG_W-1:0]      r_slot_mag;

    logic                  accept;
    logic [PHASE_BITS-1:0] base_phase;
    logic [PHASE_BITS-1:0] base_step;
    logic [PHASE_BITS-1:0] emit_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] n_step;
    logic [POS_BITS-1:0]   pos;
    logic [1:0]            quad;
    logic [ADDR_W-1:0]     idx;
    logic [ADDR_W-1:0]     rom_addr;
    logic [MAG_W-1:0]      rom_data;
    logic                  mem_we;
    logic                  mem_waddr;
    logic [PHASE_BITS-1:0] mem_wdata;

    assign o_stall = !((r_state == ST_IDLE) && !r_slot_valid);
    assign accept  = i_valid && !o_stall;

    // Unwritten memory after reset reads as the reset state
    always_comb begin
        base_phase = r_mem_valid ? r_rd_phase : '0;
        base_step  = r_mem_valid ? r_rd_step : PHASE_BITS'(RST_INIT_STEP);
        if (r_hold) begin
            emit_phase = '0;
            n_phase    = '0;
            n_step     = PHASE_BITS'(i_cfg.init_step);
        end else begin
            emit_phase = base_phase;
            n_phase    = base_phase + base_step;
            n_step     = base_step + PHASE_BITS'(i_cfg.step_inc);
        end
    end

    // Top bits of the phase give quadrant and table index; odd quadrants mirror
    assign pos      = emit_phase[PHASE_BITS-1 -: POS_BITS];
    assign quad     = pos[POS_BITS-1 -: 2];
    assign idx      = {1'b0, pos[SINE_LOG2-1:0]};
    assign rom_addr = quad[0] ? (ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;

    lcjt_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk (i_clk),
        .i_addr(rom_addr),
        .o_data(rom_data)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_PHASE;
        mem_wdata = n_phase;
        n_state   = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                mem_we  = 1'b1;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_STEP;
                mem_wdata = r_new_step;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State memory: one write port, both words read every cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_state_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_phase <= r_state_mem[ADDR_PHASE];
        r_rd_step  <= r_state_mem[ADDR_STEP];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mem_valid  <= 1'b0;
            r_slot_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_STEP) begin
                r_mem_valid  <= 1'b1;
                r_slot_valid <= 1'b1;
            end else if (i_tick_take) begin
                r_slot_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= i_hold_start;
        end
        if (r_state == ST_UPDATE) begin
            r_new_step <= n_step;
            r_q1       <= quad[1];
        end
        if (r_state == ST_STEP) begin
            r_slot_mag <= rom_data;
            r_slot_neg <= r_q1 && (rom_data != '0);
        end
    end

    assign o_tick.valid = r_slot_valid;
    assign o_tick.neg   = r_slot_neg;
    assign o_tick.mag   = r_slot_mag;

endmodule

`default_nettype wire

/* hw/rtl/lcjt_joint_unit.sv */
// ----------------------------------------------------------------------------
// lcjt_joint_unit
// Walks the joints of one tick, one per cycle: amplitude times sine, round to
// Q2.13, apply sign and clamp to the joint window. Stalls freeze the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lcjt_joint_unit #(
    parameter int JOINT_COUNT = lcjt_pkg::JOINT_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  lcjt_pkg::t_cfg                          i_cfg,
    input  lcjt_pkg::t_tick                         i_tick,
    output logic                                    o_tick_take,
    input  wire logic                               i_stall,
    output logic                                    o_valid,
    output logic        [lcjt_pkg::JOINT_W-1:0]     o_joint_index,
    output logic signed [lcjt_pkg::POS_W-1:0]       o_target_position,
    output logic                                    o_last_joint
);
    import lcjt_pkg::*;

    localparam logic [JOINT_W-1:0] LAST_J = JOINT_W'(JOINT_COUNT - 1);

    logic                     r_run;
    logic [JOINT_W-1:0]       r_joint;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic                     r_m_valid;
    logic [PROD_W-1:0]        r_m_prod;
    logic [JOINT_W-1:0]       r_m_joint;
    logic                     r_m_sneg;
    logic                     r_m_last;
    logic                     r_out_valid;
    logic [JOINT_W-1:0]       r_out_joint;
    logic signed [POS_W-1:0]  r_out_pos;
    logic                     r_out_last;

    logic                     adv;
    logic                     issue_last;
    logic                     take;
    logic [AMP_W-1:0]         amp;
    logic [PROD_W-1:0]        rounded;
    logic signed [POS_W-1:0]  mag_s;
    logic signed [POS_W-1:0]  val;
    logic signed [POS_W-1:0]  lo;
    logic signed [POS_W-1:0]  hi;
    logic signed [POS_W-1:0]  clamped;

    assign adv        = !r_out_valid || !i_stall;
    assign issue_last = (r_joint == LAST_J);
    assign take       = i_tick.valid && (!r_run || (adv && issue_last));
    assign o_tick_take = take;

    always_comb begin
        priority if (r_joint < 4'd4) begin
            amp = i_cfg.amp_abd;
        end else if (r_joint < 4'd8) begin
            amp = i_cfg.amp_flex;
        end else begin
            amp = i_cfg.amp_knee;
        end
    end

    // Round half away from zero on the magnitude, then sign and clamp
    always_comb begin
        rounded = (r_m_prod + ROUND_HALF) >> ROUND_SHIFT;
        mag_s   = signed'(POS_W'(rounded));
        val     = r_m_sneg ? -mag_s : mag_s;
        lo      = clamp_lo(r_m_joint);
        hi      = clamp_hi(r_m_joint);
        clamped = val;
        if (val < lo) begin
            clamped = lo;
        end
        if (val > hi) begin
            clamped = hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_joint     <= '0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_run   <= 1'b1;
                r_joint <= '0;
            end else if (r_run && adv) begin
                if (issue_last) begin
                    r_run <= 1'b0;
                end
                r_joint <= r_joint + 1'b1;
            end
            if (adv) begin
                r_m_valid   <= r_run;
                r_out_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mag <= i_tick.mag;
            r_neg <= i_tick.neg;
        end
        if (adv) begin
            r_m_prod    <= amp * r_mag;
            r_m_joint   <= r_joint;
            r_m_sneg    <= r_neg ^ i_cfg.dir_mask[r_joint];
            r_m_last    <= issue_last;
            r_out_joint <= r_m_joint;
            r_out_pos   <= clamped;
            r_out_last  <= r_m_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_joint_index     = r_out_joint;
    assign o_target_position = r_out_pos;
    assign o_last_joint      = r_out_last;

endmodule

`default_nettype wire

/* hw/rtl/lcjt_checker.sv */
// ----------------------------------------------------------------------------
// lcjt_checker
// Port-level checks of the joint target stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcjt_checker #(
    parameter int JOINT_COUNT = lcjt_pkg::JOINT_COUNT_DEF
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic        [lcjt_pkg::JOINT_W-1:0] o_joint_index,
    input wire logic signed [lcjt_pkg::POS_W-1:0]   o_target_position,
    input wire logic                               o_last_joint
);
    import lcjt_pkg::*;

    localparam logic [JOINT_W-1:0] LAST_J = JOINT_W'(JOINT_COUNT - 1);

    // Held beat on a stalled output
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_joint_index)
            && $stable(o_target_position) && $stable(o_last_joint)))
        else $error("output beat changed under stall");

    // Joints of a tick come out back to back in order
    a_joint_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_joint) |=>
            (o_valid && (o_joint_index == $past(o_joint_index) + 4'd1)))
        else $error("joint sequence broken within a tick");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_joint) |-> (o_joint_index == LAST_J))
        else $error("last flag on wrong joint");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_target_position >= -16'sd9599)
            && (o_target_position <= 16'sd9599)))
        else $error("target outside every joint window");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind linear_chirp_joint_targets lcjt_checker #(
    .JOINT_COUNT(JOINT_COUNT)
) u_lcjt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_joint_index    (o_joint_index),
    .o_target_position(o_target_position),
    .o_last_joint     (o_last_joint)
);

`default_nettype wire
